// File: rtl/clcd_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// Holds payload structs, configuration struct, opcode and state encodings.
// No dependencies.
package clcd_pkg;

  // Columns that a cursor placement may address
  localparam int unsigned VISIBLE_COLUMNS = 16;

  // Display command bytes
  localparam logic [7:0] CMD_FUNC_4BIT   = 8'h02;
  localparam logic [7:0] CMD_FUNC_2LINE  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_ROW0_BASE   = 8'h80;
  localparam logic [7:0] CMD_ROW1_BASE   = 8'hC0;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_INIT   = 3'd3,
    OP_CURSOR = 3'd4,
    OP_CLEAR  = 3'd5
  } clcd_op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE_PULSE = 2'd0,
    REG_NIBBLE_GAP   = 2'd1,
    REG_SETTLE       = 2'd2,
    REG_POWER_ON     = 2'd3
  } clcd_reg_e;

  // Sequencer phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_POWER  = 7'b0000010,
    PH_HI     = 7'b0000100,
    PH_GAP    = 7'b0001000,
    PH_LO     = 7'b0010000,
    PH_SETTLE = 7'b0100000,
    PH_EXTRA  = 7'b1000000
  } clcd_phase_e;

  // Running script
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_INIT  = 2'd1,
    KIND_CLEAR = 2'd2
  } clcd_kind_e;

  typedef struct packed {
    logic [15:0] enable_pulse_ticks;
    logic [15:0] nibble_gap_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] power_on_ticks;
  } clcd_cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } clcd_in_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       reg_select;
    logic       enable_line;
    logic       busy_res;
    logic       accepted;
  } clcd_out_t;

  typedef struct packed {
    clcd_phase_e phase;
    logic [15:0] wait_count;
    logic [7:0]  held_byte;
    logic        held_select;
    logic [2:0]  script_step;
    clcd_kind_e  script_kind;
    logic [3:0]  nibble;
    logic        strobe;
  } clcd_state_t;

endpackage

// File: rtl/clcd_cfg_regs.sv
// Configuration register file for the character LCD nibble sequencer.
// Holds the four tick counts; depends on clcd_pkg.
module clcd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output clcd_pkg::clcd_cfg_t cfg_o
);
  import clcd_pkg::*;

  clcd_cfg_t cfg_d, cfg_q;

  // Always ready: each write is registered
  assign cfg_ready_o = 1'b1;

  // Pick the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE_PULSE: cfg_d.enable_pulse_ticks = cfg_data_i;
        REG_NIBBLE_GAP:   cfg_d.nibble_gap_ticks   = cfg_data_i;
        REG_SETTLE:       cfg_d.settle_ticks       = cfg_data_i;
        REG_POWER_ON:     cfg_d.power_on_ticks     = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_pulse_ticks <= 16'd1;
      cfg_q.nibble_gap_ticks   <= 16'd200;
      cfg_q.settle_ticks       <= 16'd2000;
      cfg_q.power_on_ticks     <= 16'd20000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/clcd_core.sv
// Sequencer state and next-state logic for the character LCD nibble sequencer.
// Each accepted item updates the registered state; depends on clcd_pkg.
module clcd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clcd_pkg::clcd_cfg_t cfg_i,
  input  logic                in_fire_i,
  input  clcd_pkg::clcd_in_t  in_data_i,
  output clcd_pkg::clcd_out_t res_o
);
  import clcd_pkg::*;

  clcd_state_t state_d, state_q;
  logic        acc;

  // Init script byte for a given step
  function automatic logic [7:0] init_byte(logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = CMD_FUNC_4BIT;
      3'd1:    b = CMD_FUNC_2LINE;
      3'd2:    b = CMD_DISPLAY_ON;
      3'd3:    b = CMD_ENTRY_MODE;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

  // Load a byte and raise enable with its high nibble
  function automatic clcd_state_t start_byte(clcd_state_t s, logic [7:0] b, logic sel,
                                             logic [15:0] pulse);
    clcd_state_t r;
    r             = s;
    r.held_byte   = b;
    r.held_select = sel;
    r.nibble      = b[7:4];
    r.strobe      = 1'b1;
    r.phase       = PH_HI;
    r.wait_count  = pulse;
    return r;
  endfunction

  // Drop back to idle, keeping the line levels
  function automatic clcd_state_t go_idle(clcd_state_t s);
    clcd_state_t r;
    r             = s;
    r.phase       = PH_IDLE;
    r.wait_count  = '0;
    r.script_kind = KIND_NONE;
    r.script_step = '0;
    return r;
  endfunction

  // Advance the running script by one step
  function automatic clcd_state_t next_script(clcd_state_t s, clcd_cfg_t c);
    clcd_state_t r;
    r             = s;
    r.script_step = s.script_step + 3'd1;
    unique case (s.script_kind)
      KIND_INIT: begin
        if (s.script_step < 3'd5) begin
          r = start_byte(r, init_byte(s.script_step), 1'b0, c.enable_pulse_ticks);
        end else if (s.script_step == 3'd5) begin
          r.phase      = PH_EXTRA;
          r.wait_count = c.settle_ticks;
        end else begin
          r = go_idle(r);
        end
      end
      KIND_CLEAR: begin
        if (s.script_step == 3'd0) begin
          r = start_byte(r, CMD_CLEAR, 1'b0, c.enable_pulse_ticks);
        end else if (s.script_step == 3'd1) begin
          r.phase      = PH_EXTRA;
          r.wait_count = c.settle_ticks;
        end else if (s.script_step == 3'd2) begin
          r = start_byte(r, CMD_ROW0_BASE, 1'b0, c.enable_pulse_ticks);
        end else begin
          r = go_idle(r);
        end
      end
      default: r = go_idle(r);
    endcase
    return r;
  endfunction

  // Let one tick of time pass
  function automatic clcd_state_t tick(clcd_state_t s, clcd_cfg_t c);
    clcd_state_t r;
    r = s;
    if (s.phase != PH_IDLE) begin
      if (s.wait_count > 16'd1) begin
        r.wait_count = s.wait_count - 16'd1;
      end else begin
        unique case (s.phase)
          PH_POWER, PH_SETTLE, PH_EXTRA: r = next_script(s, c);
          PH_HI: begin
            r.strobe     = 1'b0;
            r.phase      = PH_GAP;
            r.wait_count = c.nibble_gap_ticks;
          end
          PH_GAP: begin
            r.nibble     = s.held_byte[3:0];
            r.strobe     = 1'b1;
            r.phase      = PH_LO;
            r.wait_count = c.enable_pulse_ticks;
          end
          PH_LO: begin
            r.strobe     = 1'b0;
            r.phase      = PH_SETTLE;
            r.wait_count = c.settle_ticks;
          end
          default: begin
            r.strobe = 1'b0;
            r        = go_idle(r);
          end
        endcase
      end
    end
    return r;
  endfunction

  // Work out the state after this item
  always_comb begin
    clcd_state_t req;
    logic [7:0]  cur_byte;
    req      = state_q;
    cur_byte = (in_data_i.row[0] ? CMD_ROW1_BASE : CMD_ROW0_BASE)
               | {4'h0, in_data_i.column[3:0]};
    state_d  = state_q;
    acc      = 1'b0;
    req.script_kind = KIND_NONE;
    req.script_step = '0;
    unique case (in_data_i.opcode)
      OP_TICK: state_d = tick(state_q, cfg_i);
      OP_CMD, OP_DATA, OP_INIT, OP_CURSOR, OP_CLEAR: begin
        if (state_q.phase == PH_IDLE) begin
          acc     = 1'b1;
          state_d = req;
          unique case (in_data_i.opcode)
            OP_CMD:  state_d = start_byte(req, in_data_i.byte_value, 1'b0,
                                          cfg_i.enable_pulse_ticks);
            OP_DATA: state_d = start_byte(req, in_data_i.byte_value, 1'b1,
                                          cfg_i.enable_pulse_ticks);
            OP_INIT: begin
              state_d.script_kind = KIND_INIT;
              state_d.held_select = 1'b0;
              state_d.phase       = PH_POWER;
              state_d.wait_count  = cfg_i.power_on_ticks;
            end
            OP_CURSOR: begin
              if (in_data_i.column < 6'(VISIBLE_COLUMNS) && in_data_i.row <= 2'd1) begin
                state_d = start_byte(req, cur_byte, 1'b0, cfg_i.enable_pulse_ticks);
              end
            end
            default: begin
              req.script_kind = KIND_CLEAR;
              state_d         = next_script(req, cfg_i);
            end
          endcase
        end
      end
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_IDLE;
      state_q.wait_count  <= '0;
      state_q.held_byte   <= '0;
      state_q.held_select <= 1'b0;
      state_q.script_step <= '0;
      state_q.script_kind <= KIND_NONE;
      state_q.nibble      <= '0;
      state_q.strobe      <= 1'b0;
    end else if (in_fire_i) begin
      state_q <= state_d;
    end
  end

  // Result seen after this item
  assign res_o.data_nibble = state_d.nibble;
  assign res_o.reg_select  = state_d.held_select;
  assign res_o.enable_line = state_d.strobe;
  assign res_o.busy_res    = (state_d.phase != PH_IDLE);
  assign res_o.accepted    = acc;

  // Enable is only ever high while a nibble strobe is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.strobe |-> (state_q.phase == PH_HI || state_q.phase == PH_LO))
    else $error("enable high outside a strobe phase");

  // Idle leaves no script or wait behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |->
      (state_q.script_kind == KIND_NONE && state_q.script_step == 3'd0
       && state_q.wait_count == 16'd0))
    else $error("idle with stale script state");

endmodule

// File: rtl/clcd_out_buf.sv
// Output register with one skid entry for the character LCD nibble sequencer.
// Keeps the input side moving while a result waits; depends on clcd_pkg.
module clcd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clcd_pkg::clcd_out_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clcd_pkg::clcd_out_t out_data_o
);
  import clcd_pkg::*;

  logic      out_valid_d, out_valid_q;
  logic      skid_valid_d, skid_valid_q;
  clcd_out_t out_data_d, out_data_q;
  clcd_out_t skid_data_d, skid_data_q;
  logic      take;

  assign take = out_valid_q && !out_stall_i;

  // Refill the output from the skid first, then from a new item
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The skid entry is only used behind a waiting output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // A held skid entry keeps its item while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> (skid_valid_q && $stable(skid_data_q)))
    else $error("skid entry lost under stall");

endmodule

// File: rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer (4-bit bus display driver).
// Instantiates clcd_cfg_regs, clcd_core and clcd_out_buf; depends on clcd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one item per request
//   or per time tick. Opcode 0 is a tick, 1 a command byte, 2 a data byte,
//   3 the init script, 4 cursor placement, 5 clear. Feed a tick every cycle
//   that should count as time; requests made while busy come back with
//   accepted low.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per item, in order, carrying the display line levels, busy and
//   whether the request was taken.
//   Config channel (cfg_valid_i / cfg_ready_o): write the tick counts only
//   while no item is in flight; ready is always high.
//   Result: registered, in the output entry or, while it waits, the skid entry.
//   Throughput: one item per cycle while in_stall_o is low; the whole state
//   update is one pass of logic into the sequencer state register.
//   Stall: one skid entry absorbs an item while the output waits; in_stall_o
//   rises once that entry is occupied.
//   Reset: counts return to 1/200/2000/20000, the sequencer goes idle with
//   all display lines low, and both output entries empty.
module char_lcd_nibble_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clcd_pkg::clcd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clcd_pkg::clcd_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import clcd_pkg::*;

  clcd_cfg_t cfg;
  clcd_out_t res;
  logic      in_fire;
  logic      buf_full;

  // Take an item whenever the skid entry is free
  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  clcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  clcd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  clcd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
